FILE: src/sem_pkg.sv
// Shared types and constants for the streaming RGB Sobel edge magnitude core.
// No dependencies; every other file of the block imports this package.
package sem_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int WIDTH_W    = 12;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   typedef logic [PIX_W-1:0] pix_type;
   // window[row][col], row 0 is the oldest line, col 2 is the newest column
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PIX,
      S_DRD,
      S_LAUNCH,
      S_CALC,
      S_OUT
   } state_type;

   // line buffer access: one read address and one write for both lines
   typedef struct packed {
      logic             rd_en;
      logic [COL_W-1:0] rd_addr;
      logic             wr_en;
      logic [COL_W-1:0] wr_addr;
      pix_type          wr_above;
      pix_type          wr_two_above;
   } lb_req_type;

endpackage

FILE: src/sem_req_if.sv
// Request channel: pixel or drain item with valid/ready handshake.
// Depends on sem_pkg for field widths.
interface sem_req_if import sem_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [CHAN_W-1:0] in_blue;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_red;

   modport source (output valid, opcode, in_blue, in_green, in_red, input ready);
   modport sink   (input valid, opcode, in_blue, in_green, in_red, output ready);
endinterface

FILE: src/sem_rsp_if.sv
// Response channel: one edge magnitude pixel with its position.
// Depends on sem_pkg for field widths.
interface sem_rsp_if import sem_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] edge_blue;
   logic [CHAN_W-1:0] edge_green;
   logic [CHAN_W-1:0] edge_red;
   logic [ROW_W-1:0]  out_row;
   logic [COL_W-1:0]  out_col;
   logic              last_of_frame;

   modport source (output valid, edge_blue, edge_green, edge_red, out_row, out_col,
                   last_of_frame, input ready);
   modport sink   (input valid, edge_blue, edge_green, edge_red, out_row, out_col,
                   last_of_frame, output ready);
endinterface

FILE: src/sem_line_mem.sv
// Two line buffers (previous row and the row before it), synchronous RAMs.
// Depends on sem_pkg; read data is registered.
module sem_line_mem import sem_pkg::*; (
   input  logic       clock,
   input  lb_req_type lb_req,
   output pix_type    rd_above,
   output pix_type    rd_two_above
);

   pix_type line_above_mem     [MAX_WIDTH];
   pix_type line_two_above_mem [MAX_WIDTH];
   pix_type rd_above_ff;
   pix_type rd_two_above_ff;

   // write port
   always_ff @(posedge clock) begin
      if (lb_req.wr_en) begin
         line_above_mem[lb_req.wr_addr]     <= lb_req.wr_above;
         line_two_above_mem[lb_req.wr_addr] <= lb_req.wr_two_above;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (lb_req.rd_en) begin
         rd_above_ff     <= line_above_mem[lb_req.rd_addr];
         rd_two_above_ff <= line_two_above_mem[lb_req.rd_addr];
      end
   end

   assign rd_above     = rd_above_ff;
   assign rd_two_above = rd_two_above_ff;

endmodule

FILE: src/sem_grad_unit.sv
// Gradient magnitude unit: Sobel Gx/Gy per channel, squares, bit-serial
// square root with rounding and clamp. Depends on sem_pkg.
module sem_grad_unit import sem_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  win_type                   win,
   output logic                      done,
   output logic [2:0][CHAN_W-1:0]    edge_val
);

   localparam logic [3:0] STEP_GRAD  = 4'd0;
   localparam logic [3:0] STEP_SQ    = 4'd1;
   localparam logic [3:0] STEP_ROUND = 4'd10;
   localparam logic [20:0] SQ_CLAMP  = 21'd65280;   // 255.5 squared, floored

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [3:0]             step_ff, step_in;
   win_type                win_ff;
   logic signed [10:0]     gx_ff [3];
   logic signed [10:0]     gy_ff [3];
   logic signed [10:0]     gx_in [3];
   logic signed [10:0]     gy_in [3];
   logic [20:0]            s_ff [3];
   logic [20:0]            s_in [3];
   logic [CHAN_W-1:0]      root_ff [3];
   logic [CHAN_W-1:0]      root_in [3];
   logic [2:0][CHAN_W-1:0] edge_ff;
   logic [2:0][CHAN_W-1:0] edge_in;

   // control sequencer
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_GRAD;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         if (step_ff == STEP_ROUND) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_GRAD;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath per channel
   always_comb begin
      logic [9:0]  px, nx, py, ny;
      logic [21:0] sqx, sqy;
      logic [7:0]  mask, trial;
      logic [15:0] tsq;
      logic [16:0] nn;
      mask = 8'd1 << 3'(4'd9 - step_ff);
      for (int ch = 0; ch < 3; ch++) begin
         px = 10'(win_ff[0][2][8*ch +: 8]) + {1'b0, win_ff[1][2][8*ch +: 8], 1'b0}
            + 10'(win_ff[2][2][8*ch +: 8]);
         nx = 10'(win_ff[0][0][8*ch +: 8]) + {1'b0, win_ff[1][0][8*ch +: 8], 1'b0}
            + 10'(win_ff[2][0][8*ch +: 8]);
         py = 10'(win_ff[2][0][8*ch +: 8]) + {1'b0, win_ff[2][1][8*ch +: 8], 1'b0}
            + 10'(win_ff[2][2][8*ch +: 8]);
         ny = 10'(win_ff[0][0][8*ch +: 8]) + {1'b0, win_ff[0][1][8*ch +: 8], 1'b0}
            + 10'(win_ff[0][2][8*ch +: 8]);
         gx_in[ch] = $signed({1'b0, px}) - $signed({1'b0, nx});
         gy_in[ch] = $signed({1'b0, py}) - $signed({1'b0, ny});

         sqx = 22'(gx_ff[ch] * gx_ff[ch]);
         sqy = 22'(gy_ff[ch] * gy_ff[ch]);
         s_in[ch] = 21'(sqx + sqy);

         // one root bit per cycle, MSB first
         trial = root_ff[ch] | mask;
         tsq   = 16'(trial) * 16'(trial);
         root_in[ch] = root_ff[ch];
         if (step_ff == STEP_SQ) begin
            root_in[ch] = '0;
         end else if (step_ff > STEP_SQ && step_ff < STEP_ROUND) begin
            if (21'(tsq) <= s_ff[ch]) root_in[ch] = trial;
         end

         // round to nearest and clamp
         nn = 17'(root_ff[ch]) * 17'(root_ff[ch]) + 17'(root_ff[ch]);
         if (s_ff[ch] > SQ_CLAMP) begin
            edge_in[ch] = 8'd255;
         end else if (21'(nn) < s_ff[ch]) begin
            edge_in[ch] = root_ff[ch] + 8'd1;
         end else begin
            edge_in[ch] = root_ff[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) win_ff <= win;
      for (int ch = 0; ch < 3; ch++) begin
         if (step_ff == STEP_GRAD) begin
            gx_ff[ch] <= gx_in[ch];
            gy_ff[ch] <= gy_in[ch];
         end
         if (step_ff == STEP_SQ) s_ff[ch] <= s_in[ch];
         root_ff[ch] <= root_in[ch];
      end
      if (busy_ff && step_ff == STEP_ROUND) edge_ff <= edge_in;
   end

   assign done     = done_ff;
   assign edge_val = edge_ff;

endmodule

FILE: src/sobel_edge_magnitude_rgb_core.sv
// Streaming 3x3 Sobel edge magnitude core for RGB pixels, one item at a time.
// Depends on sem_pkg, sem_req_if, sem_rsp_if, sem_line_mem, sem_grad_unit.
//
// Pixels enter in raster order; output (r,c) leaves once pixel (r+1,c+1) has
// arrived, the last column at the row's end, and the final row one pixel per
// drain request. Each request is handled on its own: a pixel request that
// produces no result passes through accept, line buffer read and dispatch; each
// result adds launch, the shared magnitude unit, which resolves the square root
// one bit per cycle, and the handoff to the response slot, plus any wait for
// that slot. A drain request also fetches three columns, one after another,
// through the single line buffer read port. The response register lets
// a new request start while a finished result waits. Writing either frame
// register restarts the frame position.
module sobel_edge_magnitude_rgb_core import sem_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sem_req_if.sink               req_ch,
   sem_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type              state_ff, state_in;
   logic [WIDTH_W-1:0]     width_ff, width_in;
   logic [HEIGHT_W-1:0]    height_ff, height_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       drain_ff, drain_in;
   logic                   draining_ff, draining_in;
   logic                   emit1_ff, emit1_in;
   logic                   emit2_ff, emit2_in;
   logic [1:0]             k_ff, k_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pix_type                pix_ff, pix_in;
   win_type                win_ff, win_in;
   logic [COL_W-1:0]       e1_col_ff, e1_col_in;
   logic [COL_W-1:0]       e2_col_ff, e2_col_in;
   logic [ROW_W-1:0]       meta_row_ff, meta_row_in;
   logic                   e1_last_ff, e1_last_in;
   logic [COL_W-1:0]       cur_col_ff, cur_col_in;
   logic                   cur_last_ff, cur_last_in;
   logic [2:0][CHAN_W-1:0] rsp_edge_ff, rsp_edge_in;
   logic [ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]       rsp_col_ff, rsp_col_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [WIDTH_W-1:0]     eff_w;
   logic [HEIGHT_W-1:0]    eff_h;
   lb_req_type             lb_req;
   pix_type                rd_above, rd_two_above;
   logic                   unit_start, unit_done;
   win_type                unit_win;
   win_type                shifted_win;
   logic [2:0][CHAN_W-1:0] unit_edge;
   logic                   req_acc;
   logic                   slot_free;

   sem_line_mem u_line_mem (
      .clock        (clock),
      .lb_req       (lb_req),
      .rd_above     (rd_above),
      .rd_two_above (rd_two_above)
   );

   sem_grad_unit u_grad_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .win      (unit_win),
      .done     (unit_done),
      .edge_val (unit_edge)
   );

   // effective frame size, clamped to the supported range
   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) eff_w = WIDTH_W'(1);
      else if (width_ff > WIDTH_W'(MAX_WIDTH)) eff_w = WIDTH_W'(MAX_WIDTH);
      eff_h = height_ff;
      if (height_ff == '0) eff_h = HEIGHT_W'(1);
      else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) eff_h = HEIGHT_W'(MAX_HEIGHT);
   end

   // last-column window: shift left, zero beyond the right edge
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted_win[i][0] = win_ff[i][1];
         shifted_win[i][1] = win_ff[i][2];
         shifted_win[i][2] = '0;
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && (state_ff == S_IDLE);
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   // sequencer
   always_comb begin
      logic [COL_W:0]  dcol;
      logic            ok;
      state_in    = state_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      draining_in = draining_ff;
      emit1_in    = emit1_ff;
      emit2_in    = emit2_ff;
      k_in        = k_ff;
      pix_in      = pix_ff;
      win_in      = win_ff;
      e1_col_in   = e1_col_ff;
      e2_col_in   = e2_col_ff;
      meta_row_in = meta_row_ff;
      e1_last_in  = e1_last_ff;
      cur_col_in  = cur_col_ff;
      cur_last_in = cur_last_ff;
      rsp_edge_in = rsp_edge_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      unit_start  = 1'b0;
      unit_win    = win_ff;
      lb_req      = '0;
      dcol        = {1'b0, drain_ff} + (COL_W+1)'(k_ff);
      ok          = (dcol != '0) && (dcol <= (COL_W+1)'(eff_w));

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (op_type'(req_ch.opcode) == OP_PIXEL) begin
                  if (!draining_ff) begin
                     pix_in         = {req_ch.in_red, req_ch.in_green, req_ch.in_blue};
                     lb_req.rd_en   = 1'b1;
                     lb_req.rd_addr = col_ff;
                     state_in       = S_PIX;
                  end
               end else if (draining_ff) begin
                  lb_req.rd_en   = 1'b1;
                  lb_req.rd_addr = drain_ff - COL_W'(1);
                  k_in           = 2'd0;
                  state_in       = S_DRD;
               end
            end
         end

         S_PIX: begin
            // shift the window, new column from line buffers and the pixel
            for (int i = 0; i < 3; i++) begin
               win_in[i][0] = (col_ff == '0) ? '0 : win_ff[i][1];
               win_in[i][1] = (col_ff == '0) ? '0 : win_ff[i][2];
            end
            win_in[0][2] = (row_ff >= ROW_W'(2)) ? rd_two_above : '0;
            win_in[1][2] = (row_ff >= ROW_W'(1)) ? rd_above : '0;
            win_in[2][2] = pix_ff;
            lb_req.wr_en        = 1'b1;
            lb_req.wr_addr      = col_ff;
            lb_req.wr_above     = pix_ff;
            lb_req.wr_two_above = rd_above;
            emit1_in    = (row_ff != '0) && (col_ff != '0);
            emit2_in    = (row_ff != '0) && ((WIDTH_W'(col_ff) + WIDTH_W'(1)) == eff_w);
            e1_col_in   = col_ff - COL_W'(1);
            e2_col_in   = col_ff;
            meta_row_in = row_ff - ROW_W'(1);
            e1_last_in  = 1'b0;
            // frame position
            if ((WIDTH_W'(col_ff) + WIDTH_W'(1)) >= eff_w) begin
               col_in = '0;
               if ((HEIGHT_W'(row_ff) + HEIGHT_W'(1)) >= eff_h) begin
                  row_in      = '0;
                  drain_in    = '0;
                  draining_in = 1'b1;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            state_in = S_LAUNCH;
         end

         S_DRD: begin
            // one column of the last-row window per cycle
            win_in[0][k_ff] = (ok && eff_h >= HEIGHT_W'(2)) ? rd_two_above : '0;
            win_in[1][k_ff] = ok ? rd_above : '0;
            win_in[2][k_ff] = '0;
            if (k_ff != 2'd2) begin
               lb_req.rd_en   = 1'b1;
               lb_req.rd_addr = drain_ff + COL_W'(k_ff);
               k_in           = k_ff + 2'd1;
            end else begin
               emit1_in    = 1'b1;
               emit2_in    = 1'b0;
               e1_col_in   = drain_ff;
               meta_row_in = ROW_W'(eff_h - HEIGHT_W'(1));
               e1_last_in  = ((WIDTH_W'(drain_ff) + WIDTH_W'(1)) == eff_w);
               if ((WIDTH_W'(drain_ff) + WIDTH_W'(1)) >= eff_w) begin
                  col_in      = '0;
                  row_in      = '0;
                  drain_in    = '0;
                  draining_in = 1'b0;
               end else begin
                  drain_in = drain_ff + COL_W'(1);
               end
               state_in = S_LAUNCH;
            end
         end

         S_LAUNCH: begin
            if (emit1_ff) begin
               unit_start  = 1'b1;
               unit_win    = win_ff;
               cur_col_in  = e1_col_ff;
               cur_last_in = e1_last_ff;
               emit1_in    = 1'b0;
               state_in    = S_CALC;
            end else if (emit2_ff) begin
               unit_start  = 1'b1;
               unit_win    = shifted_win;
               cur_col_in  = e2_col_ff;
               cur_last_in = 1'b0;
               emit2_in    = 1'b0;
               state_in    = S_CALC;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_CALC: begin
            if (unit_done) state_in = S_OUT;
         end

         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_edge_in  = unit_edge;
               rsp_row_in   = meta_row_ff;
               rsp_col_in   = cur_col_ff;
               rsp_last_in  = cur_last_ff;
               state_in     = S_LAUNCH;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes restart the frame
      if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_FRAME_WIDTH:  width_in  = csr_wdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: height_in = csr_wdata[HEIGHT_W-1:0];
            default:          width_in  = width_ff;
         endcase
         col_in      = '0;
         row_in      = '0;
         drain_in    = '0;
         draining_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WIDTH_W'(640);
         height_ff    <= HEIGHT_W'(480);
         col_ff       <= '0;
         row_ff       <= '0;
         drain_ff     <= '0;
         draining_ff  <= 1'b0;
         emit1_ff     <= 1'b0;
         emit2_ff     <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         drain_ff     <= drain_in;
         draining_ff  <= draining_in;
         emit1_ff     <= emit1_in;
         emit2_ff     <= emit2_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      e1_col_ff   <= e1_col_in;
      e2_col_ff   <= e2_col_in;
      meta_row_ff <= meta_row_in;
      e1_last_ff  <= e1_last_in;
      cur_col_ff  <= cur_col_in;
      cur_last_ff <= cur_last_in;
      rsp_edge_ff <= rsp_edge_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.edge_blue     = rsp_edge_ff[0];
   assign rsp_ch.edge_green    = rsp_edge_ff[1];
   assign rsp_ch.edge_red      = rsp_edge_ff[2];
   assign rsp_ch.out_row       = rsp_row_ff;
   assign rsp_ch.out_col       = rsp_col_ff;
   assign rsp_ch.last_of_frame = rsp_last_ff;

endmodule
